>>> rtl/svm_pkg.sv
`default_nettype none

package svm_pkg;

  localparam int MAX_ELEMENTS  = 4;
  localparam int FRACTION_BITS = 16;
  localparam int LANES         = 4;
  localparam int ROOT_STEPS    = 32;
  localparam int NUM_W         = 32 + FRACTION_BITS;

  localparam logic signed [67:0] WORD_MAX = 68'sd2147483647;
  localparam logic signed [67:0] WORD_MIN = -68'sd2147483648;
  localparam logic signed [67:0] HALF_LSB = 68'sd1 <<< (FRACTION_BITS - 1);

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_SCALE     = 4'd2,
    OP_DOT       = 4'd3,
    OP_LENGTH    = 4'd4,
    OP_NORMALIZE = 4'd5,
    OP_LERP      = 4'd6,
    OP_DISTANCE  = 4'd7,
    OP_CROSS     = 4'd8
  } op_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [2:0]         dimension;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic signed [31:0] factor;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_w;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic [3:0]         op;
    logic               act;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] a;
    logic signed [32:0] s;
  } lane_in_t;

  typedef struct packed {
    logic [31:0]        elem;
    logic               sat;
    logic [63:0]        sq;
    logic signed [65:0] pr;
  } lane_out_t;

  typedef struct packed {
    logic [3:0]             op;
    logic [2:0]             dims;
    logic [LANES-1:0][31:0] res;
    logic                   sat;
    logic [LANES-1:0][31:0] mag;
    logic [LANES-1:0]       neg;
  } side_t;

  // {saturated, word}
  function automatic logic [32:0] clip_word(input logic signed [67:0] v);
    if (v > WORD_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (v < WORD_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // round half up to the fixed point grid
  function automatic logic signed [67:0] round_fix(input logic signed [67:0] v);
    return (v + HALF_LSB) >>> FRACTION_BITS;
  endfunction

endpackage

`default_nettype wire

>>> rtl/svm_if.sv
`default_nettype none

interface svm_in_if;
  import svm_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface svm_out_if;
  import svm_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/small_vector_math_unit.sv
`default_nettype none

// Pipelined Q16.16 vector unit for 2 to 4 element vectors: add, sub, scale, dot, length,
// normalize, lerp, distance and 3-D cross. One word is taken every cycle and every word
// leaves in order, whatever its operation, through the 32-stage square root and then the
// (33 + FRACTION_BITS)-stage divider that normalize needs. The whole pipeline holds while
// a finished word is not taken. Scalar answers come in res_x, unused elements are zero,
// and saturated is set when any element was clipped.
module small_vector_math_unit (
  input  logic       clk,
  input  logic       rst,
  svm_in_if.sink     req,
  svm_out_if.source  rsp
);
  import svm_pkg::*;

  logic en;
  logic v_a, v_b, v_c, v_m, v_e, v_f;

  // stage A: operand selection
  logic signed [31:0] av [LANES];
  logic signed [31:0] bv [LANES];
  logic signed [32:0] dv [LANES];
  logic [2:0]         dims_n;
  lane_in_t           lin_n [LANES];
  lane_in_t           lin_a [LANES];
  logic [3:0]         op_a, op_b, op_c;
  logic [2:0]         dims_a, dims_b, dims_c;
  logic [LANES-1:0][31:0] mag_n, mag_a, mag_b, mag_c;
  logic [LANES-1:0]   neg_a, neg_b, neg_c;

  lane_out_t          lout [LANES];

  // merge stage
  logic [65:0]        ssum;
  logic signed [67:0] dsum;
  logic [32:0]        dot_cw;
  side_t              side_n, side_m;
  logic [63:0]        rad_m;
  logic               big_m;

  logic               v_r;
  logic [31:0]        root_r;
  logic [33:0]        rem_r;
  logic               big_r;
  side_t              side_r;

  logic [32:0]        len_n, len_e;
  side_t              side_en, side_e;

  logic               v_d;
  logic [NUM_W-1:0]   quo_d [LANES];
  logic [32:0]        len_d;
  side_t              side_d;

  logic [LANES-1:0][31:0] res_n;
  logic               sat_n;
  logic signed [67:0] qv [LANES];
  logic [32:0]        qcw [LANES];
  out_word_t          out_q;

  assign en        = !v_f || rsp.ready;
  assign req.ready = en;
  assign rsp.valid = v_f;
  assign rsp.data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_m <= 1'b0;
      v_e <= 1'b0;
      v_f <= 1'b0;
    end else if (en) begin
      v_a <= req.valid;
      v_b <= v_a;
      v_c <= v_b;
      v_m <= v_c;
      v_e <= v_r;
      v_f <= v_d;
    end
  end

  always_comb begin
    av[0] = req.data.a_x;
    av[1] = req.data.a_y;
    av[2] = req.data.a_z;
    av[3] = req.data.a_w;
    bv[0] = req.data.b_x;
    bv[1] = req.data.b_y;
    bv[2] = req.data.b_z;
    bv[3] = req.data.b_w;
    if (req.data.dimension > 3'(MAX_ELEMENTS)) begin
      dims_n = 3'(MAX_ELEMENTS);
    end else if (req.data.dimension < 3'd2) begin
      dims_n = 3'd2;
    end else begin
      dims_n = req.data.dimension;
    end
    for (int i = 0; i < LANES; i++) begin
      dv[i]        = 33'(bv[i]) - 33'(av[i]);
      mag_n[i]     = av[i][31] ? 32'(33'sd0 - 33'(av[i])) : av[i];
      lin_n[i].op  = req.data.kind;
      lin_n[i].act = (req.data.kind == OP_CROSS) ? (i < 3) : (i < int'(dims_n));
      lin_n[i].a   = av[i];
      lin_n[i].s   = (req.data.kind == OP_SUB) ? 33'(av[i]) - 33'(bv[i])
                                               : 33'(av[i]) + 33'(bv[i]);
      lin_n[i].x   = '0;
      lin_n[i].y   = '0;
      lin_n[i].u   = '0;
      lin_n[i].v   = '0;
      unique case (req.data.kind)
        OP_SCALE: begin
          lin_n[i].x = 33'(av[i]);
          lin_n[i].y = 33'(req.data.factor);
        end
        OP_DOT: begin
          lin_n[i].x = 33'(av[i]);
          lin_n[i].y = 33'(bv[i]);
        end
        OP_LENGTH, OP_NORMALIZE: begin
          lin_n[i].x = 33'(av[i]);
          lin_n[i].y = 33'(av[i]);
        end
        OP_DISTANCE: begin
          lin_n[i].x = dv[i];
          lin_n[i].y = dv[i];
        end
        OP_LERP: begin
          lin_n[i].x = dv[i];
          lin_n[i].y = 33'(req.data.factor);
        end
        OP_CROSS: begin
          if (i < 3) begin
            lin_n[i].x = 33'(av[(i+1)%3]);
            lin_n[i].y = 33'(bv[(i+2)%3]);
            lin_n[i].u = av[(i+2)%3];
            lin_n[i].v = bv[(i+1)%3];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        lin_a[i] <= lin_n[i];
        neg_a[i] <= av[i][31];
      end
      mag_a  <= mag_n;
      op_a   <= req.data.kind;
      dims_a <= dims_n;
      mag_b  <= mag_a;
      neg_b  <= neg_a;
      op_b   <= op_a;
      dims_b <= dims_a;
      mag_c  <= mag_b;
      neg_c  <= neg_b;
      op_c   <= op_b;
      dims_c <= dims_b;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    svm_lane u_lane (
      .clk  (clk),
      .en   (en),
      .lin  (lin_a[g]),
      .lout (lout[g])
    );
  end

  // merge lanes: sums of squares and products
  always_comb begin
    ssum = '0;
    dsum = '0;
    for (int i = 0; i < LANES; i++) begin
      ssum = ssum + 66'(lout[i].sq);
      dsum = dsum + 68'(lout[i].pr);
    end
    dot_cw      = clip_word(round_fix(dsum));
    side_n.op   = op_c;
    side_n.dims = dims_c;
    side_n.mag  = mag_c;
    side_n.neg  = neg_c;
    side_n.sat  = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      side_n.res[i] = lout[i].elem;
      side_n.sat    = side_n.sat | lout[i].sat;
    end
    if (op_c == OP_DOT) begin
      side_n.res[0] = dot_cw[31:0];
      side_n.sat    = dot_cw[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_m <= side_n;
      rad_m  <= ssum[63:0];
      big_m  <= |ssum[65:64];
    end
  end

  svm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (v_m),
    .rad_in   (rad_m),
    .big_in   (big_m),
    .side_in  (side_m),
    .vout     (v_r),
    .root_out (root_r),
    .rem_out  (rem_r),
    .big_out  (big_r),
    .side_out (side_r)
  );

  // rounded length
  always_comb begin
    if (big_r) begin
      len_n = 33'd1 << 32;
    end else begin
      len_n = 33'(root_r) + 33'(rem_r > {2'b00, root_r});
    end
    side_en = side_r;
    if (side_r.op == OP_LENGTH || side_r.op == OP_DISTANCE) begin
      if (len_n[32] || len_n[31]) begin
        side_en.res[0] = 32'h7FFF_FFFF;
        side_en.sat    = 1'b1;
      end else begin
        side_en.res[0] = len_n[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_e  <= len_n;
      side_e <= side_en;
    end
  end

  svm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (v_e),
    .len_in   (len_e),
    .side_in  (side_e),
    .vout     (v_d),
    .quo_out  (quo_d),
    .len_out  (len_d),
    .side_out (side_d)
  );

  always_comb begin
    res_n = side_d.res;
    sat_n = side_d.sat;
    for (int i = 0; i < LANES; i++) begin
      qv[i]  = side_d.neg[i] ? 68'sd0 - $signed(68'(quo_d[i])) : $signed(68'(quo_d[i]));
      qcw[i] = clip_word(qv[i]);
    end
    if (side_d.op == OP_NORMALIZE) begin
      sat_n = 1'b0;
      for (int i = 0; i < LANES; i++) begin
        if (len_d != '0 && i < int'(side_d.dims)) begin
          res_n[i] = qcw[i][31:0];
          sat_n    = sat_n | qcw[i][32];
        end else begin
          res_n[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q.res_x     <= res_n[0];
      out_q.res_y     <= res_n[1];
      out_q.res_z     <= res_n[2];
      out_q.res_w     <= res_n[3];
      out_q.saturated <= sat_n;
    end
  end

endmodule

`default_nettype wire

>>> rtl/svm_lane.sv
`default_nettype none

module svm_lane (
  input  logic                 clk,
  input  logic                 en,
  input  svm_pkg::lane_in_t    lin,
  output svm_pkg::lane_out_t   lout
);
  import svm_pkg::*;

  logic signed [65:0] p0;
  logic signed [63:0] p1;
  logic [3:0]         op;
  logic               act;
  logic signed [31:0] a;
  logic signed [32:0] s;

  logic signed [66:0] v;
  logic signed [67:0] r;
  logic signed [67:0] e;
  logic               use_elem;
  logic [32:0]        cw;

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= $signed(lin.x) * $signed(lin.y);
      p1  <= $signed(lin.u) * $signed(lin.v);
      op  <= lin.op;
      act <= lin.act;
      a   <= lin.a;
      s   <= lin.s;
    end
  end

  always_comb begin
    v = $signed({p0[65], p0});
    if (op == OP_CROSS) begin
      v = v - $signed({{3{p1[63]}}, p1});
    end
    r = round_fix($signed({v[66], v}));
    e = '0;
    use_elem = 1'b1;
    unique case (op)
      OP_ADD, OP_SUB:    e = 68'(s);
      OP_SCALE, OP_CROSS: e = r;
      OP_LERP:           e = r + 68'(a);
      default:           use_elem = 1'b0;
    endcase
    cw = clip_word(e);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lout.elem <= (act && use_elem) ? cw[31:0] : '0;
      lout.sat  <= act && use_elem && cw[32];
      lout.sq   <= (act && (op == OP_LENGTH || op == OP_NORMALIZE || op == OP_DISTANCE))
                   ? p0[63:0] : '0;
      lout.pr   <= (act && op == OP_DOT) ? p0 : '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/svm_sqrt.sv
`default_nettype none

module svm_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vin,
  input  logic [63:0]     rad_in,
  input  logic            big_in,
  input  svm_pkg::side_t  side_in,
  output logic            vout,
  output logic [31:0]     root_out,
  output logic [33:0]     rem_out,
  output logic            big_out,
  output svm_pkg::side_t  side_out
);
  import svm_pkg::*;

  logic        vld_q  [ROOT_STEPS];
  logic [63:0] rad_q  [ROOT_STEPS];
  logic [31:0] root_q [ROOT_STEPS];
  logic [33:0] rem_q  [ROOT_STEPS];
  logic        big_q  [ROOT_STEPS];
  side_t       side_q [ROOT_STEPS];

  logic [63:0] rad_s     [ROOT_STEPS];
  logic [31:0] root_s    [ROOT_STEPS];
  logic [33:0] rem_s     [ROOT_STEPS];
  logic [35:0] cur       [ROOT_STEPS];
  logic [35:0] trial     [ROOT_STEPS];
  logic [31:0] root_next [ROOT_STEPS];
  logic [33:0] rem_next  [ROOT_STEPS];

  // one result bit per stage, two radicand bits consumed
  always_comb begin
    for (int k = 0; k < ROOT_STEPS; k++) begin
      if (k == 0) begin
        rad_s[k]  = rad_in;
        root_s[k] = '0;
        rem_s[k]  = '0;
      end else begin
        rad_s[k]  = rad_q[k-1];
        root_s[k] = root_q[k-1];
        rem_s[k]  = rem_q[k-1];
      end
      cur[k]   = {rem_s[k], rad_s[k][63:62]};
      trial[k] = {2'b00, root_s[k], 2'b01};
      if (cur[k] >= trial[k]) begin
        rem_next[k]  = 34'(cur[k] - trial[k]);
        root_next[k] = {root_s[k][30:0], 1'b1};
      end else begin
        rem_next[k]  = cur[k][33:0];
        root_next[k] = {root_s[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROOT_STEPS; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < ROOT_STEPS; k++) vld_q[k] <= (k == 0) ? vin : vld_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
        rad_q[k]  <= rad_s[k] << 2;
        root_q[k] <= root_next[k];
        rem_q[k]  <= rem_next[k];
        big_q[k]  <= (k == 0) ? big_in : big_q[k-1];
        side_q[k] <= (k == 0) ? side_in : side_q[k-1];
      end
    end
  end

  assign vout     = vld_q[ROOT_STEPS-1];
  assign root_out = root_q[ROOT_STEPS-1];
  assign rem_out  = rem_q[ROOT_STEPS-1];
  assign big_out  = big_q[ROOT_STEPS-1];
  assign side_out = side_q[ROOT_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/svm_div.sv
`default_nettype none

module svm_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vin,
  input  logic [32:0]            len_in,
  input  svm_pkg::side_t         side_in,
  output logic                   vout,
  output logic [svm_pkg::NUM_W-1:0] quo_out [svm_pkg::LANES],
  output logic [32:0]            len_out,
  output svm_pkg::side_t         side_out
);
  import svm_pkg::*;

  localparam int STAGES = NUM_W + 1;

  logic             vld_q  [STAGES];
  logic [32:0]      len_q  [STAGES];
  side_t            side_q [STAGES];
  logic [NUM_W-1:0] num_q  [STAGES][LANES];
  logic [32:0]      rem_q  [STAGES][LANES];
  logic [NUM_W-1:0] quo_q  [STAGES][LANES];

  logic [33:0]      cur      [STAGES][LANES];
  logic [32:0]      rem_next [STAGES][LANES];
  logic             bit_next [STAGES][LANES];

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          cur[k][l]      = '0;
          rem_next[k][l] = '0;
          bit_next[k][l] = 1'b0;
        end else begin
          cur[k][l] = {rem_q[k-1][l], num_q[k-1][l][NUM_W-1]};
          if (cur[k][l] >= {1'b0, len_q[k-1]}) begin
            rem_next[k][l] = 33'(cur[k][l] - {1'b0, len_q[k-1]});
            bit_next[k][l] = 1'b1;
          end else begin
            rem_next[k][l] = cur[k][l][32:0];
            bit_next[k][l] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < STAGES; k++) vld_q[k] <= (k == 0) ? vin : vld_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_q[0]  <= len_in;
      side_q[0] <= side_in;
      for (int l = 0; l < LANES; l++) begin
        num_q[0][l] <= {side_in.mag[l], {FRACTION_BITS{1'b0}}} + NUM_W'(len_in >> 1);
        rem_q[0][l] <= '0;
        quo_q[0][l] <= '0;
      end
      for (int k = 1; k < STAGES; k++) begin
        len_q[k]  <= len_q[k-1];
        side_q[k] <= side_q[k-1];
        for (int l = 0; l < LANES; l++) begin
          num_q[k][l] <= num_q[k-1][l] << 1;
          rem_q[k][l] <= rem_next[k][l];
          quo_q[k][l] <= {quo_q[k-1][l][NUM_W-2:0], bit_next[k][l]};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) quo_out[l] = quo_q[STAGES-1][l];
  end
  assign vout     = vld_q[STAGES-1];
  assign len_out  = len_q[STAGES-1];
  assign side_out = side_q[STAGES-1];

endmodule

`default_nettype wire
